FILE: rtl/tbm_pkg.sv
// Package for the token bus membership controller.
// Holds payload structs, configuration struct, and the mode, action and opcode constants.
// No dependencies.
`default_nettype none

package tbm_pkg;

  // Input beat
  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] msg_kind;
    logic       not_for_me;
    logic [7:0] sender_addr;
  } tbm_in_t;

  // Result beat
  typedef struct packed {
    logic [2:0] action;
    logic       send_allowed;
    logic [7:0] receiver_addr;
    logic [2:0] node_mode;
  } tbm_out_t;

  // Classified item between front and back
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] msg;
    logic       other;
    logic [7:0] addr;
  } tbm_op_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0]  own_address;
    logic [15:0] max_wait_ticks;
    logic [15:0] loop_period;
    logic [15:0] short_break_phase;
    logic [15:0] long_break_phase;
    logic [15:0] token_lost_ticks;
  } tbm_cfg_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_OWN_ADDRESS = 3'd0;
  localparam logic [2:0] CFG_MAX_WAIT    = 3'd1;
  localparam logic [2:0] CFG_LOOP_PERIOD = 3'd2;
  localparam logic [2:0] CFG_SHORT_BREAK = 3'd3;
  localparam logic [2:0] CFG_LONG_BREAK  = 3'd4;
  localparam logic [2:0] CFG_TOKEN_LOST  = 3'd5;

  // Input commands
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_MSG    = 2'd1;
  localparam logic [1:0] CMD_SENDER = 2'd2;

  // Received message kinds
  localparam logic [1:0] MSG_ENABLE  = 2'd0;
  localparam logic [1:0] MSG_INFO    = 2'd1;
  localparam logic [1:0] MSG_REQUEST = 2'd2;

  // Classified operations
  localparam logic [1:0] OP_NOP    = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_MSG    = 2'd2;
  localparam logic [1:0] OP_SENDER = 2'd3;

  // Actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_CHANGED = 3'd1;
  localparam logic [2:0] ACT_ENABLE  = 3'd2;
  localparam logic [2:0] ACT_REQUEST = 3'd3;
  localparam logic [2:0] ACT_INFO    = 3'd4;

  // Node modes
  localparam logic [2:0] MODE_UNKNOWN = 3'd0;
  localparam logic [2:0] MODE_REBOOT  = 3'd1;
  localparam logic [2:0] MODE_SINGLE  = 3'd2;
  localparam logic [2:0] MODE_UNREG   = 3'd3;
  localparam logic [2:0] MODE_REG     = 3'd4;

  localparam logic [7:0] ADDR_NONE = 8'd255;

endpackage

`default_nettype wire

FILE: rtl/tbm_front.sv
// Front end: accepts input beats, classifies them and holds them in a two-entry queue.
// Depends on tbm_pkg.
`default_nettype none

module tbm_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire tbm_pkg::tbm_in_t in_data,
  output logic                  op_valid,
  output tbm_pkg::tbm_op_t      op,
  input  wire logic             pop
);
  import tbm_pkg::*;

  tbm_op_t    q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  tbm_op_t    cls;

  // Classify the incoming beat
  always_comb begin
    cls.kind  = OP_NOP;
    cls.msg   = in_data.msg_kind;
    cls.other = in_data.not_for_me;
    cls.addr  = in_data.sender_addr;
    case (in_data.cmd)
      CMD_TICK:   cls.kind = OP_TICK;
      CMD_MSG:    cls.kind = (in_data.msg_kind == MSG_ENABLE ||
                              in_data.msg_kind == MSG_INFO ||
                              in_data.msg_kind == MSG_REQUEST) ? OP_MSG : OP_NOP;
      CMD_SENDER: cls.kind = OP_SENDER;
      default:    cls.kind = OP_NOP;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign op_valid = (cnt_r != 2'd0);
  assign op       = q_r[rd_ptr_r];

  // Advance queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Store the classified beat
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cls;
  end

endmodule

`default_nettype wire

FILE: rtl/tbm_divider.sv
// Iterative remainder unit: 16-bit dividend modulo 16-bit divisor, four bits per cycle.
// Depends on tbm_pkg (no items used beyond the import convention).
`default_nettype none

module tbm_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [15:0]      rem
);
  import tbm_pkg::*;

  localparam int WIDTH      = 16;
  localparam int BITS_CYCLE = 4;
  localparam int CYCLES     = WIDTH / BITS_CYCLE;

  logic [WIDTH-1:0]         rem_r, rem_nxt;
  logic [WIDTH-1:0]         quo_r, quo_nxt;
  logic [WIDTH-1:0]         div_r;
  logic [$clog2(CYCLES)-1:0] cnt_r;
  logic                     busy_r;
  logic                     done_r;
  logic [WIDTH:0]           trial;

  // Four restoring steps per cycle
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int i = 0; i < BITS_CYCLE; i++) begin
      trial   = {rem_nxt, quo_nxt[WIDTH-1]};
      quo_nxt = {quo_nxt[WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) trial = trial - {1'b0, div_r};
      rem_nxt = trial[WIDTH-1:0];
    end
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + ($clog2(CYCLES))'(1);
        if (cnt_r == ($clog2(CYCLES))'(CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Hold operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

FILE: rtl/tbm_back.sv
// Back end: membership state machine, loop timer, neighbour tracking and result register.
// Depends on tbm_pkg and tbm_divider.
`default_nettype none

module tbm_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tbm_pkg::tbm_cfg_t cfg,
  input  wire logic              op_valid,
  input  wire tbm_pkg::tbm_op_t  op,
  output logic                   pop,
  output logic                   div_start,
  output logic                   div_done,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tbm_pkg::tbm_out_t      out_data
);
  import tbm_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  // Loop events
  localparam logic [2:0] EV_ENABLE  = 3'd0;
  localparam logic [2:0] EV_INFO    = 3'd1;
  localparam logic [2:0] EV_REQUEST = 3'd2;
  localparam logic [2:0] EV_START   = 3'd3;
  localparam logic [2:0] EV_SHORT   = 3'd4;
  localparam logic [2:0] EV_LONG    = 3'd5;
  localparam logic [2:0] EV_TIMEOUT = 3'd6;

  logic        state_r, state_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [7:0]  rn_r, rn_nxt;
  logic [7:0]  ls_r, ls_nxt;
  logic        ms_r, ms_nxt;
  logic [15:0] let_r, let_nxt;
  logic        out_valid_r;
  tbm_out_t    out_data_r;

  logic        slot_free;
  logic        is_tick;
  logic        is_op;
  logic        commit;
  logic        ev_valid;
  logic [2:0]  ev;
  logic        other;
  logic [2:0]  act;
  logic [15:0] ph;
  logic [15:0] div_rem;
  logic        lost;
  logic [7:0]  recv_cur;
  logic [7:0]  recv_nxt;

  tbm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (timer_r),
    .divisor  (cfg.loop_period),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign pop       = (state_r == ST_IDLE) && op_valid && slot_free;
  assign div_start = pop && (op.kind == OP_TICK);
  assign is_tick   = (state_r == ST_DIV) && div_done;
  assign is_op     = pop && (op.kind != OP_TICK);
  assign commit    = is_tick || is_op;

  assign recv_cur = (rn_r != ADDR_NONE) ? rn_r : ((ls_r != ADDR_NONE) ? ls_r : 8'd0);
  assign lost     = ({1'b0, let_r} + {1'b0, cfg.token_lost_ticks}) <= {1'b0, timer_r};
  assign ph       = (cfg.loop_period == 16'd0) ? timer_r : div_rem;

  // Sequence the fetch and the remainder wait
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (div_start) state_nxt = ST_DIV;
      ST_DIV:  if (div_done)  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Derive the event, dispatch it and advance the timer
  always_comb begin
    mode_nxt  = mode_r;
    timer_nxt = timer_r;
    rn_nxt    = rn_r;
    ls_nxt    = ls_r;
    ms_nxt    = ms_r;
    let_nxt   = let_r;
    act       = ACT_NONE;
    ev_valid  = 1'b0;
    ev        = EV_ENABLE;
    other     = 1'b0;

    if (is_tick) begin
      if (timer_r >= cfg.max_wait_ticks) begin
        ev_valid = 1'b1;
        ev       = EV_TIMEOUT;
      end else if (ph == 16'd0) begin
        ev_valid = 1'b1;
        ev       = EV_START;
      end else if (ph == cfg.short_break_phase) begin
        ev_valid = 1'b1;
        ev       = EV_SHORT;
      end else if (ph == cfg.long_break_phase) begin
        ev_valid = 1'b1;
        ev       = EV_LONG;
      end
    end

    if (is_op && op.kind == OP_MSG) begin
      ev_valid = 1'b1;
      ev       = {1'b0, op.msg};
      other    = op.other;
    end

    // Track right neighbour and lowest address
    if (is_op && op.kind == OP_SENDER) begin
      if (cfg.own_address < op.addr && rn_r > op.addr) rn_nxt = op.addr;
      if (op.addr < ls_r) ls_nxt = op.addr;
    end

    if (ev_valid) begin
      case (mode_r)
        MODE_UNKNOWN, MODE_REBOOT: begin
          ms_nxt = 1'b0;
          case (ev)
            EV_ENABLE: begin
              timer_nxt = 16'd0;
              act       = ACT_CHANGED;
              if (other) begin
                mode_nxt = MODE_UNREG;
              end else begin
                mode_nxt = MODE_REG;
                ms_nxt   = 1'b1;
              end
            end
            EV_REQUEST: begin
              timer_nxt = 16'd0;
              mode_nxt  = MODE_UNREG;
              act       = ACT_INFO;
            end
            EV_START: begin
              if (mode_r == MODE_REBOOT) begin
                act = (recv_cur == 8'd0) ? ACT_REQUEST : ACT_ENABLE;
              end else if (timer_r == 16'd0) begin
                rn_nxt = ADDR_NONE;
                ls_nxt = ADDR_NONE;
              end
            end
            EV_TIMEOUT: begin
              timer_nxt = 16'd0;
              mode_nxt  = (mode_r == MODE_UNKNOWN) ? MODE_REBOOT : MODE_SINGLE;
              act       = ACT_CHANGED;
            end
            default: act = ACT_NONE;
          endcase
        end
        MODE_SINGLE: begin
          case (ev)
            EV_ENABLE: begin
              timer_nxt = 16'd0;
              act       = ACT_CHANGED;
              if (other) begin
                mode_nxt = MODE_UNREG;
              end else begin
                mode_nxt = MODE_REG;
                ms_nxt   = 1'b1;
              end
            end
            EV_INFO: begin
              ms_nxt    = 1'b0;
              timer_nxt = 16'd0;
              mode_nxt  = MODE_UNKNOWN;
              act       = ACT_CHANGED;
            end
            EV_REQUEST: begin
              ms_nxt    = 1'b0;
              timer_nxt = 16'd0;
              mode_nxt  = MODE_UNREG;
              act       = ACT_INFO;
            end
            EV_START: begin
              ms_nxt = 1'b0;
              act    = ACT_REQUEST;
            end
            EV_SHORT:   ms_nxt = 1'b1;
            EV_TIMEOUT: timer_nxt = 16'd0;
            default:    act = ACT_NONE;
          endcase
        end
        MODE_UNREG: begin
          ms_nxt = 1'b0;
          case (ev)
            EV_ENABLE: begin
              // A foreign enable still reports a change while the mode holds
              act = ACT_CHANGED;
              if (!other) begin
                timer_nxt = 16'd0;
                mode_nxt  = MODE_REG;
                ms_nxt    = 1'b1;
              end
            end
            EV_REQUEST: act = ACT_INFO;
            EV_TIMEOUT: begin
              timer_nxt = 16'd0;
              mode_nxt  = MODE_UNKNOWN;
              act       = ACT_CHANGED;
            end
            default: act = ACT_NONE;
          endcase
        end
        MODE_REG: begin
          case (ev)
            EV_ENABLE: begin
              if (!other) begin
                ms_nxt    = 1'b1;
                timer_nxt = 16'd0;
              end else begin
                ms_nxt  = 1'b0;
                let_nxt = timer_r;
              end
            end
            EV_SHORT: begin
              if (timer_r == cfg.short_break_phase || lost) begin
                let_nxt = timer_r;
                ms_nxt  = 1'b0;
                act     = (rn_r == ADDR_NONE && !lost) ? ACT_REQUEST : ACT_ENABLE;
              end
            end
            EV_LONG: begin
              if (timer_r == cfg.long_break_phase && rn_r == ADDR_NONE &&
                  ls_r != ADDR_NONE) act = ACT_ENABLE;
            end
            EV_TIMEOUT: begin
              timer_nxt = 16'd0;
              mode_nxt  = MODE_UNREG;
              act       = ACT_CHANGED;
            end
            default: act = ACT_NONE;
          endcase
        end
        default: act = ACT_NONE;
      endcase
    end

    // Advance the timer unless the tick changed state
    if (is_tick && act != ACT_CHANGED) timer_nxt = timer_nxt + 16'd1;
  end

  assign recv_nxt = (rn_nxt != ADDR_NONE) ? rn_nxt :
                    ((ls_nxt != ADDR_NONE) ? ls_nxt : 8'd0);

  // Hold node state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MODE_UNKNOWN;
      timer_r <= 16'd0;
      rn_r    <= ADDR_NONE;
      ls_r    <= ADDR_NONE;
      ms_r    <= 1'b0;
      let_r   <= 16'd0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        mode_r  <= mode_nxt;
        timer_r <= timer_nxt;
        rn_r    <= rn_nxt;
        ls_r    <= ls_nxt;
        ms_r    <= ms_nxt;
        let_r   <= let_nxt;
      end
    end
  end

  // Load the result register, drop it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r.action        <= act;
      out_data_r.send_allowed  <= ms_nxt;
      out_data_r.receiver_addr <= recv_nxt;
      out_data_r.node_mode     <= mode_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/token_bus_membership_fsm.sv
// Top level of the token bus membership controller: configuration registers,
// front queue and back state machine. Depends on tbm_pkg, tbm_front, tbm_back.
//
//   Channel | Direction | Handshake            | Payload
//   in_     | input     | in_valid / in_ready   | tbm_in_t  in_data
//   out_    | output    | out_valid / out_ready | tbm_out_t out_data
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index[2:0], cfg_data[15:0]
//
// A message, sender report or ignored item passes through the front queue and the result register.
// A tick also waits on the remainder unit for its loop phase; the unit retires four
// quotient bits a cycle until done, and the state and result registers then load.
// Reset is synchronous, active low; registers load their listed reset values.
// Two queued items drop in_ready low, as when a result waits on out_ready; cfg_ready is
// always high.
`default_nettype none

module token_bus_membership_fsm (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tbm_pkg::tbm_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tbm_pkg::tbm_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);
  import tbm_pkg::*;

  tbm_cfg_t cfg_r;
  logic     op_valid;
  tbm_op_t  op;
  logic     pop;
  logic     div_start;
  logic     div_done;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address       <= 8'd1;
      cfg_r.max_wait_ticks    <= 16'd1000;
      cfg_r.loop_period       <= 16'd100;
      cfg_r.short_break_phase <= 16'd10;
      cfg_r.long_break_phase  <= 16'd50;
      cfg_r.token_lost_ticks  <= 16'd300;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OWN_ADDRESS: cfg_r.own_address       <= cfg_data[7:0];
        CFG_MAX_WAIT:    cfg_r.max_wait_ticks    <= cfg_data;
        CFG_LOOP_PERIOD: cfg_r.loop_period       <= cfg_data;
        CFG_SHORT_BREAK: cfg_r.short_break_phase <= cfg_data;
        CFG_LONG_BREAK:  cfg_r.long_break_phase  <= cfg_data;
        CFG_TOKEN_LOST:  cfg_r.token_lost_ticks  <= cfg_data;
        default:         cfg_r <= cfg_r;
      endcase
    end
  end

  tbm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .op_valid (op_valid),
    .op       (op),
    .pop      (pop)
  );

  tbm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .op_valid  (op_valid),
    .op        (op),
    .pop       (pop),
    .div_start (div_start),
    .div_done  (div_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Queue is read only when it holds an item
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> op_valid)
    else $error("queue popped while empty");

  // Remainder unit is never restarted while it works
  a_start_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_start)
    else $error("remainder unit restarted early");

  // Each remainder completion is checked against the start that began it
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> $past(div_start, 5))
    else $error("remainder done without matching start");

  // Reported mode is one of the five node modes
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.node_mode <= MODE_REG))
    else $error("result carries an undefined node mode");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Testbench for token_bus_membership_fsm: directed and random beats, each result checked
// field by field against an in-bench model of the node membership state machine.
// Depends on tbm_pkg and the token_bus_membership_fsm RTL.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tbm_pkg::*;

  // Codes the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] MSG_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_PRINTED = 40;

  // Loop and message events seen by the membership logic
  typedef enum logic [2:0] {
    EVT_ENABLE, EVT_INFO, EVT_REQUEST, EVT_START, EVT_SHORT, EVT_LONG, EVT_TIMEOUT
  } bus_event_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  tbm_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  tbm_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Node model: state and register copies
  logic [2:0]  cur_mode;
  logic [15:0] loop_timer;
  logic [7:0]  right_nb;
  logic [7:0]  lowest_addr;
  logic        may_send;
  logic [15:0] last_enable_at;
  logic [7:0]  own_addr;
  logic [15:0] max_wait;
  logic [15:0] loop_len;
  logic [15:0] short_phase;
  logic [15:0] long_phase;
  logic [15:0] lost_ticks;

  tbm_out_t    pending_results[$];
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned hold_off_cycles = 0;
  bit          gaps_on = 1'b1;
  logic [7:0]  modes_seen = '0;

  token_bus_membership_fsm i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Node model
  // ---------------------------------------------------------------------------

  function automatic void reset_node();
    own_addr       = 8'd1;
    max_wait       = 16'd1000;
    loop_len       = 16'd100;
    short_phase    = 16'd10;
    long_phase     = 16'd50;
    lost_ticks     = 16'd300;
    cur_mode       = MODE_UNKNOWN;
    loop_timer     = '0;
    right_nb       = ADDR_NONE;
    lowest_addr    = ADDR_NONE;
    may_send       = 1'b0;
    last_enable_at = '0;
  endfunction

  function automatic void load_register(logic [2:0] idx, logic [15:0] data);
    case (idx)
      CFG_OWN_ADDRESS: own_addr = data[7:0];
      CFG_MAX_WAIT:    max_wait = data;
      CFG_LOOP_PERIOD: loop_len = data;
      CFG_SHORT_BREAK: short_phase = data;
      CFG_LONG_BREAK:  long_phase = data;
      CFG_TOKEN_LOST:  lost_ticks = data;
      default:         own_addr = own_addr;
    endcase
  endfunction

  // Neighbour first, then lowest address seen, else zero
  function automatic logic [7:0] token_receiver();
    if (right_nb != ADDR_NONE) return right_nb;
    if (lowest_addr != ADDR_NONE) return lowest_addr;
    return 8'd0;
  endfunction

  function automatic void enter_mode(logic [2:0] next_mode);
    loop_timer = '0;
    cur_mode   = next_mode;
  endfunction

  function automatic logic [2:0] take_enable(bit other);
    if (other) begin
      enter_mode(MODE_UNREG);
    end else begin
      enter_mode(MODE_REG);
      may_send = 1'b1;
    end
    return ACT_CHANGED;
  endfunction

  // Pass the token at a short break when the timer equals the short phase or the token counts as lost
  function automatic logic [2:0] registered_short_break();
    bit lost;
    lost = ({1'b0, last_enable_at} + {1'b0, lost_ticks}) <= {1'b0, loop_timer};
    if (loop_timer == short_phase || lost) begin
      last_enable_at = loop_timer;
      may_send = 1'b0;
      if (right_nb == ADDR_NONE && !lost) return ACT_REQUEST;
      return ACT_ENABLE;
    end
    return ACT_NONE;
  endfunction

  function automatic logic [2:0] raise_event(bus_event_e ev, bit other);
    case (cur_mode)
      MODE_UNKNOWN, MODE_REBOOT: begin
        may_send = 1'b0;
        case (ev)
          EVT_ENABLE: return take_enable(other);
          EVT_REQUEST: begin
            enter_mode(MODE_UNREG);
            return ACT_INFO;
          end
          EVT_START: begin
            if (cur_mode == MODE_REBOOT) begin
              return (token_receiver() == 8'd0) ? ACT_REQUEST : ACT_ENABLE;
            end
            if (loop_timer == 16'd0) begin
              right_nb    = ADDR_NONE;
              lowest_addr = ADDR_NONE;
            end
            return ACT_NONE;
          end
          EVT_TIMEOUT: begin
            enter_mode((cur_mode == MODE_UNKNOWN) ? MODE_REBOOT : MODE_SINGLE);
            return ACT_CHANGED;
          end
          default: return ACT_NONE;
        endcase
      end
      MODE_SINGLE: begin
        case (ev)
          EVT_ENABLE: return take_enable(other);
          EVT_INFO: begin
            may_send = 1'b0;
            enter_mode(MODE_UNKNOWN);
            return ACT_CHANGED;
          end
          EVT_REQUEST: begin
            may_send = 1'b0;
            enter_mode(MODE_UNREG);
            return ACT_INFO;
          end
          EVT_START: begin
            may_send = 1'b0;
            return ACT_REQUEST;
          end
          EVT_SHORT: begin
            may_send = 1'b1;
            return ACT_NONE;
          end
          EVT_TIMEOUT: begin
            loop_timer = '0;
            return ACT_NONE;
          end
          default: return ACT_NONE;
        endcase
      end
      MODE_UNREG: begin
        may_send = 1'b0;
        case (ev)
          EVT_ENABLE: begin
            // an enable for another node still reports a change
            if (!other) begin
              enter_mode(MODE_REG);
              may_send = 1'b1;
            end
            return ACT_CHANGED;
          end
          EVT_REQUEST: return ACT_INFO;
          EVT_TIMEOUT: begin
            enter_mode(MODE_UNKNOWN);
            return ACT_CHANGED;
          end
          default: return ACT_NONE;
        endcase
      end
      MODE_REG: begin
        case (ev)
          EVT_ENABLE: begin
            if (!other) begin
              may_send   = 1'b1;
              loop_timer = '0;
            end else begin
              may_send       = 1'b0;
              last_enable_at = loop_timer;
            end
            return ACT_NONE;
          end
          EVT_SHORT: return registered_short_break();
          EVT_LONG: begin
            if (loop_timer == long_phase && right_nb == ADDR_NONE && lowest_addr != ADDR_NONE)
              return ACT_ENABLE;
            return ACT_NONE;
          end
          EVT_TIMEOUT: begin
            enter_mode(MODE_UNREG);
            return ACT_CHANGED;
          end
          default: return ACT_NONE;
        endcase
      end
      default: return ACT_NONE;
    endcase
  endfunction

  // Raise the loop event for the current timer, then advance unless the mode changed
  function automatic logic [2:0] advance_tick();
    logic [2:0]  act;
    logic [15:0] phase;
    act = ACT_NONE;
    if (loop_timer >= max_wait) begin
      act = raise_event(EVT_TIMEOUT, 1'b0);
    end else begin
      if (loop_len != 16'd0) phase = loop_timer % loop_len;
      else phase = loop_timer;
      if (phase == 16'd0) act = raise_event(EVT_START, 1'b0);
      else if (phase == short_phase) act = raise_event(EVT_SHORT, 1'b0);
      else if (phase == long_phase) act = raise_event(EVT_LONG, 1'b0);
    end
    if (act != ACT_CHANGED) loop_timer = loop_timer + 16'd1;
    return act;
  endfunction

  function automatic tbm_out_t predict_beat(tbm_in_t item);
    tbm_out_t res;
    logic [2:0] act;
    act = ACT_NONE;
    case (item.cmd)
      CMD_TICK: act = advance_tick();
      CMD_MSG: begin
        case (item.msg_kind)
          MSG_ENABLE:  act = raise_event(EVT_ENABLE, item.not_for_me);
          MSG_INFO:    act = raise_event(EVT_INFO, item.not_for_me);
          MSG_REQUEST: act = raise_event(EVT_REQUEST, item.not_for_me);
          default:     act = ACT_NONE;
        endcase
      end
      CMD_SENDER: begin
        if (own_addr < item.sender_addr && right_nb > item.sender_addr)
          right_nb = item.sender_addr;
        if (item.sender_addr < lowest_addr) lowest_addr = item.sender_addr;
      end
      default: act = ACT_NONE;
    endcase
    res.action        = act;
    res.send_allowed  = may_send;
    res.receiver_addr = token_receiver();
    res.node_mode     = cur_mode;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  // Check results first, then queue the prediction for a beat taken on this edge
  always @(posedge clk) begin : check_results
    tbm_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected: %h",
                                    results_seen, out_data));
        end else begin
          want = pending_results.pop_front();
          if (out_data.action !== want.action)
            report_mismatch($sformatf("result %0d action: got %0d, want %0d",
                                      results_seen, out_data.action, want.action));
          if (out_data.send_allowed !== want.send_allowed)
            report_mismatch($sformatf("result %0d send_allowed: got %0b, want %0b",
                                      results_seen, out_data.send_allowed,
                                      want.send_allowed));
          if (out_data.receiver_addr !== want.receiver_addr)
            report_mismatch($sformatf("result %0d receiver_addr: got %0d, want %0d",
                                      results_seen, out_data.receiver_addr,
                                      want.receiver_addr));
          if (out_data.node_mode !== want.node_mode)
            report_mismatch($sformatf("result %0d node_mode: got %0d, want %0d",
                                      results_seen, out_data.node_mode, want.node_mode));
        end
      end
      if (in_valid && in_ready) begin
        want = predict_beat(in_data);
        modes_seen[want.node_mode] = 1'b1;
        pending_results.push_back(want);
      end
      if (cfg_valid && cfg_ready) load_register(cfg_index, cfg_data);
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped at cycle limit %0d with %0d results outstanding",
               cycles, items_sent - results_seen);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus long hold-offs on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned stall;
    int unsigned held;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        out_ready <= 1'b0;
        held = 0;
        while (held < hold_off_cycles) begin
          @(posedge clk);
          held++;
        end
        hold_off_cycles = 0;
        out_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic tbm_in_t make_item(logic [1:0] cmd, logic [1:0] kind, logic other,
                                        logic [7:0] addr);
    tbm_in_t item;
    item.cmd         = cmd;
    item.msg_kind    = kind;
    item.not_for_me  = other;
    item.sender_addr = addr;
    return item;
  endfunction

  // Mostly ticks so the loop timer moves; the unused fields carry noise
  function automatic tbm_in_t random_item(int unsigned tick_pct);
    tbm_in_t     item;
    int unsigned roll;
    item.msg_kind    = $urandom_range(0, 24) == 0 ? MSG_UNUSED : 2'($urandom_range(0, 2));
    item.not_for_me  = 1'($urandom_range(0, 1));
    item.sender_addr = $urandom_range(0, 49) == 0 ? 8'd255 : 8'($urandom_range(0, 254));
    roll = $urandom_range(0, 99);
    if (roll < tick_pct) item.cmd = CMD_TICK;
    else if (roll < tick_pct + 25) item.cmd = CMD_MSG;
    else if (roll < 97) item.cmd = CMD_SENDER;
    else item.cmd = CMD_UNUSED;
    return item;
  endfunction

  // Offer one beat and hold it until taken
  task automatic send_item(input tbm_in_t item);
    int unsigned gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding result, then for the tick latency
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write all six registers back to back once the block is idle
  task automatic program_regs(input logic [7:0] own, input logic [15:0] wait_lim,
                              input logic [15:0] period, input logic [15:0] short_ph,
                              input logic [15:0] long_ph, input logic [15:0] lost);
    logic [2:0]  idx [0:5];
    logic [15:0] val [0:5];
    wait_drained();
    idx[0] = CFG_OWN_ADDRESS; val[0] = {8'($urandom), own};
    idx[1] = CFG_MAX_WAIT;    val[1] = wait_lim;
    idx[2] = CFG_LOOP_PERIOD; val[2] = period;
    idx[3] = CFG_SHORT_BREAK; val[3] = short_ph;
    idx[4] = CFG_LONG_BREAK;  val[4] = long_ph;
    idx[5] = CFG_TOKEN_LOST;  val[5] = lost;
    for (int i = 0; i < 6; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count, input int unsigned tick_pct);
    repeat (count) send_item(random_item(tick_pct));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values, sender tracking, ignored commands and message kinds
  task automatic test_reset_values();
    send_item(make_item(CMD_TICK, MSG_ENABLE, 1'b0, 8'd0));
    send_item(make_item(CMD_SENDER, MSG_ENABLE, 1'b0, 8'd0));
    send_item(make_item(CMD_SENDER, MSG_REQUEST, 1'b1, 8'd254));
    send_item(make_item(CMD_SENDER, MSG_INFO, 1'b0, 8'd255));
    send_item(make_item(CMD_SENDER, MSG_ENABLE, 1'b0, 8'd2));
    send_item(make_item(CMD_UNUSED, MSG_UNUSED, 1'b1, 8'hff));
    send_item(make_item(CMD_MSG, MSG_UNUSED, 1'b1, 8'h55));
    send_item(make_item(CMD_TICK, MSG_UNUSED, 1'b1, 8'haa));
    wait_drained();
  endtask

  // Walk unknown -> reboot -> single -> unregistered -> registered with short timers
  task automatic test_mode_walk();
    program_regs(8'h10, 16'd3, 16'd5, 16'd1, 16'd2, 16'd1);
    repeat (8) send_item(make_item(CMD_TICK, MSG_ENABLE, 1'b0, 8'd0));
    send_item(make_item(CMD_MSG, MSG_REQUEST, 1'b0, 8'd0));
    send_item(make_item(CMD_MSG, MSG_ENABLE, 1'b1, 8'd0));
    send_item(make_item(CMD_MSG, MSG_ENABLE, 1'b0, 8'd0));
    repeat (4) send_item(make_item(CMD_TICK, MSG_ENABLE, 1'b0, 8'd0));
    send_item(make_item(CMD_MSG, MSG_INFO, 1'b0, 8'd0));
    send_item(make_item(CMD_MSG, MSG_ENABLE, 1'b1, 8'd0));
    send_item(make_item(CMD_SENDER, MSG_ENABLE, 1'b0, 8'h20));
    wait_drained();
  endtask

  // Hold the result side off while beats keep coming so the input stalls
  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    hold_off_cycles = 150;
    run_random(24, 60);
    wait_drained();
    gaps_on = 1'b1;
  endtask

  // Pause the sender until every result is back, then resume
  task automatic test_sender_pause();
    run_random(15, 60);
    wait_drained();
    run_random(15, 60);
    wait_drained();
  endtask

  // Random beats under a range of register settings, extremes included
  task automatic test_random_configs();
    logic [15:0] period;
    program_regs(8'($urandom_range(0, 254)), 16'd20, 16'd6, 16'd2, 16'd4, 16'd5);
    run_random(220, 60);
    program_regs(8'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    run_random(150, 60);
    program_regs(8'd254, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    run_random(120, 60);
    // zero loop period: the phase is the timer itself
    program_regs(8'($urandom_range(0, 254)), 16'd40, 16'd0, 16'd3, 16'd9, 16'd6);
    run_random(220, 65);
    for (int n = 0; n < 3; n++) begin
      period = 16'($urandom_range(2, 20));
      program_regs(8'($urandom_range(0, 254)), 16'($urandom_range(period, 80)), period,
                   16'($urandom_range(1, period + 2)), 16'($urandom_range(1, period + 2)),
                   16'($urandom_range(1, 40)));
      gaps_on = (n != 1);
      run_random(220, 60);
    end
    gaps_on = 1'b1;
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_final_stream();
    logic [15:0] period;
    period = 16'($urandom_range(2, 12));
    program_regs(8'($urandom_range(0, 254)), 16'($urandom_range(period, 50)), period,
                 16'($urandom_range(1, period)), 16'($urandom_range(1, period)),
                 16'($urandom_range(1, 30)));
    gaps_on = 1'b0;
    run_random(300, 60);
    wait_drained();
  endtask

  initial begin
    reset_node();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_mode_walk();
    test_output_backpressure();
    test_sender_pause();
    test_random_configs();
    test_final_stream();

    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));
    $display("checked %0d results from %0d beats across %0d register writes",
             results_seen, items_sent, reg_writes);
    $display("node modes reached (bit per mode): %05b", modes_seen[4:0]);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
